FILE: src/dfc_pkg.sv
package dfc_pkg;

  localparam int SettingBits = 12;
  localparam int TrialW      = $clog2(SettingBits);
  localparam int DcoW        = 12;
  localparam int CapW        = 16;
  localparam int TargetW     = 16;
  localparam int CfgDataW    = 16;
  localparam int CfgIdxW     = 1;

  localparam logic [TargetW-1:0] TargetReset = TargetW'(244);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET = 1'b0,
    CFG_TRACK  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_CAPTURE = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_FIRST    = 3'd0,
    ST_KEPT     = 3'd1,
    ST_RESTORED = 3'd2,
    ST_NONE     = 3'd3,
    ST_DOWN     = 3'd4,
    ST_UP       = 3'd5,
    ST_STARTED  = 3'd6
  } status_e;

  typedef struct packed {
    logic [TargetW-1:0] target_count;
    logic               track_enable;
  } cfg_t;

  typedef struct packed {
    logic            req_type;
    logic [CapW-1:0] capture_time;
  } item_t;

  typedef struct packed {
    logic [DcoW-1:0] dco_setting;
    logic [CapW-1:0] period_count;
    status_e         status;
    logic            searching;
  } result_t;

endpackage

FILE: src/dfc_cfg.sv
module dfc_cfg
  import dfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_count <= TargetReset;
      cfg_q.track_enable <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET: cfg_q.target_count <= cfg_wdata_i[TargetW-1:0];
        CFG_TRACK:  cfg_q.track_enable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/dfc_core.sv
module dfc_core
  import dfc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  logic    advance_i,
  output result_t result_o
);

  localparam logic [SettingBits-1:0] AllOnes = {SettingBits{1'b1}};
  localparam logic [TrialW-1:0]      TopBit  = TrialW'(SettingBits - 1);

  logic [SettingBits-1:0] setting_q, setting_d;
  logic                   active_q, active_d;
  logic [TrialW-1:0]      trial_q, trial_d;
  logic                   have_first_q, have_first_d;
  logic [CapW-1:0]        prev_q, prev_d;

  logic [CapW-1:0]        count;
  logic                   below, above;
  logic [SettingBits-1:0] trial_mask, restored;
  status_e                status;

  assign count      = item_i.capture_time - prev_q;
  assign below      = count < cfg_i.target_count;
  assign above      = count > cfg_i.target_count;
  assign trial_mask = SettingBits'(1) << trial_q;
  assign restored   = below ? (setting_q | trial_mask) : setting_q;

  always_comb begin
    setting_d    = setting_q;
    active_d     = active_q;
    trial_d      = trial_q;
    have_first_d = have_first_q;
    prev_d       = prev_q;
    status       = ST_NONE;
    if (item_i.req_type == REQ_START) begin
      setting_d    = AllOnes & ~(SettingBits'(1) << TopBit);
      active_d     = 1'b1;
      trial_d      = TopBit;
      have_first_d = 1'b0;
      status       = ST_STARTED;
    end else if (!have_first_q) begin
      prev_d       = item_i.capture_time;
      have_first_d = 1'b1;
      status       = ST_FIRST;
    end else begin
      have_first_d = 1'b0;
      if (active_q) begin
        status = below ? ST_RESTORED : ST_KEPT;
        if (trial_q == '0) begin
          setting_d = restored;
          active_d  = 1'b0;
        end else begin
          trial_d   = trial_q - TrialW'(1);
          setting_d = restored & ~(trial_mask >> 1);
        end
      end else if (cfg_i.track_enable) begin
        if (above && setting_q != '0) begin
          setting_d = setting_q - SettingBits'(1);
          status    = ST_DOWN;
        end else if (below && setting_q != AllOnes) begin
          setting_d = setting_q + SettingBits'(1);
          status    = ST_UP;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setting_q    <= AllOnes;
      active_q     <= 1'b0;
      trial_q      <= '0;
      have_first_q <= 1'b0;
      prev_q       <= '0;
    end else if (advance_i) begin
      setting_q    <= setting_d;
      active_q     <= active_d;
      trial_q      <= trial_d;
      have_first_q <= have_first_d;
      prev_q       <= prev_d;
    end
  end

  // completing pair reports the count, everything else reports zero
  assign result_o.dco_setting  = DcoW'(setting_d);
  assign result_o.period_count = (item_i.req_type == REQ_CAPTURE && have_first_q) ? count : '0;
  assign result_o.status       = status;
  assign result_o.searching    = active_d;

endmodule

FILE: src/dco_frequency_calibrator.sv
// Channel  | Valid        | Stall        | Payload
// request  | in_valid_i   | in_stall_o   | req_type_i, capture_time_i
// result   | out_valid_o  | out_stall_i  | dco_setting_o, period_count_o, status_o, searching_o
// config   | cfg_we_i     | (none)       | cfg_idx_i, cfg_wdata_i
//
// Two register stages: request register, then result register.
// One request per cycle sustained while out_stall_i is low; the state update sits between the two registers.
// Reset: setting all ones, search idle, no pending capture, target 244, tracking on.
// A stalled result holds; the request register still fills behind it, then in_stall_o rises.
module dco_frequency_calibrator
  import dfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [CapW-1:0]     capture_time_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DcoW-1:0]     dco_setting_o,
  output logic [CapW-1:0]     period_count_o,
  output logic [2:0]          status_o,
  output logic                searching_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t result_d, result_q;
  logic    out_valid_q;
  logic    out_load, in_load;

  dfc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign out_load   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_load    = in_valid_i && !in_stall_o;

  dfc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_i    (item_q),
    .advance_i (out_load),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (out_load) begin
        in_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      item_q.req_type     <= req_type_i;
      item_q.capture_time <= capture_time_i;
    end
    if (out_load) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dco_setting_o  = result_q.dco_setting;
  assign period_count_o = result_q.period_count;
  assign status_o       = result_q.status;
  assign searching_o    = result_q.searching;

endmodule
